>>> sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Word types for the command and result channels, command and status codes.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Widths of the channel fields
    localparam int FUNC_W     = 3;
    localparam int DATA_IO_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int OCC_W      = 5;
    localparam int CFG_W      = 5;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd5;
    localparam logic [FUNC_W-1:0] FN_PEEK       = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Command word
    typedef struct packed {
        logic        [FUNC_W-1:0]    func;
        logic signed [DATA_IO_W-1:0] data_in;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic        [STATUS_W-1:0]  status;
        logic signed [DATA_IO_W-1:0] data_out;
        logic        [SLOT_W-1:0]    slot_index;
        logic        [OCC_W-1:0]     occupancy;
    } out_word_t;

endpackage

>>> sv/cdq_store.sv
// ----------------------------------------------------------------------------
// Circular deque slot store
// Single-port-write, single-port-read slot memory with registered read data.
// Read data holds until the next read is issued.
// ----------------------------------------------------------------------------
module cdq_store #(
    parameter  int DEPTH      = 16,
    parameter  int DATA_WIDTH = 32,
    localparam int ADDR_W     = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write the addressed slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the addressed slot, hold the word otherwise
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/circular_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// Circular double-ended queue
// Deque of up to DEPTH words in a circular slot store, with push and pop at
// both ends, clear, peek at the front and a search walked from the front.
//
//   Channel | Direction | Handshake           | Word
//   --------+-----------+---------------------+-------------------------------
//   cfg     | in        | cfg_valid/cfg_ready | capacity (5 bits)
//   in      | in        | in_valid/in_stall   | func, data_in
//   out     | out       | out_valid/out_stall | status, data_out, slot, occupancy
//
// Push, clear and any failing command: result in the output register at the
// accepting edge. Pop and peek: the slot store registers the read word, then
// the output register takes it once the output is free. Search: one slot read
// and one compare per cycle through the single read port, and a closing step
// when no slot matches.
// Reset clears the pointers, count and output; the store is not cleared.
// A read command is taken while the previous result is still stalled at the
// output; a command whose result is immediate waits for the output to free.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_top #(
    parameter  int DEPTH      = 16,
    parameter  int DATA_WIDTH = 32,
    localparam int PTR_W      = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [cdq_pkg::CFG_W-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  cdq_pkg::in_word_t       in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output cdq_pkg::out_word_t      out_data
);

    import cdq_pkg::*;

    localparam int CMP_W = (PTR_W + 1 > CFG_W) ? PTR_W + 1 : CFG_W;
    localparam int CNT_W = CFG_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CFG_W-1:0]      cap_reg;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [PTR_W-1:0]      back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_word_reg, out_word_next;
    logic [PTR_W-1:0]      srch_ptr_reg, srch_ptr_next;
    logic [CNT_W-1:0]      srch_left_reg, srch_left_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [PTR_W-1:0]      cmp_ptr_reg, cmp_ptr_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [CMP_W-1:0]      cap_eff;
    logic [DATA_WIDTH-1:0] in_val;
    logic [DATA_IO_W-1:0]  rd_data_ext;
    logic [SLOT_W-1:0]     cmp_slot;
    logic                  out_free;
    logic                  has_entries;
    logic                  is_full;
    logic                  needs_read;
    logic                  in_fire;
    logic                  hit;
    logic                  res_load;
    out_word_t             res;

    // Step a pointer forward, wrapping at the capacity
    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                                 input logic [CMP_W-1:0] cap);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(p) + CMP_W'(1);
        return (nxt >= cap) ? '0 : PTR_W'(nxt);
    endfunction

    // Step a pointer back, wrapping from slot zero to the last slot of the capacity
    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                   input logic [CMP_W-1:0] cap);
        logic [CMP_W-1:0] last;
        last = cap - CMP_W'(1);
        return (p == '0) ? PTR_W'(last) : p - PTR_W'(1);
    endfunction

    cdq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Fit the channel data to the stored width and back
    generate
        if (DATA_WIDTH >= DATA_IO_W)
        begin : g_wide
            assign in_val      = DATA_WIDTH'(in_data.data_in);
            assign rd_data_ext = rd_data[DATA_IO_W-1:0];
        end
        else
        begin : g_narrow
            assign in_val      = in_data.data_in[DATA_WIDTH-1:0];
            assign rd_data_ext = {{(DATA_IO_W-DATA_WIDTH){1'b0}}, rd_data};
        end
        if (PTR_W >= SLOT_W)
        begin : g_slot_wide
            assign cmp_slot = cmp_ptr_reg[SLOT_W-1:0];
        end
        else
        begin : g_slot_narrow
            assign cmp_slot = {{(SLOT_W-PTR_W){1'b0}}, cmp_ptr_reg};
        end
    endgenerate

    // Clamp the capacity to the built depth, with zero taken as one
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            cap_eff = CMP_W'(DEPTH);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    // Accept control: read commands may enter while a result is stalled
    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || !out_stall;
    assign has_entries = (count_reg != '0);
    assign is_full     = (CMP_W'(count_reg) >= cap_eff);
    assign needs_read  = (in_data.func == FN_SEARCH) ||
                         (has_entries && ((in_data.func == FN_POP_FRONT) ||
                                          (in_data.func == FN_POP_BACK) ||
                                          (in_data.func == FN_PEEK)));
    assign in_stall    = (state_reg != S_IDLE) || (!needs_read && !out_free);
    assign in_fire     = in_valid && !in_stall;
    assign hit         = cmp_vld_reg && (rd_data == key_reg);

    // Command sequencing, pointer update and result forming
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        count_next     = count_reg;
        srch_ptr_next  = srch_ptr_reg;
        srch_left_next = srch_left_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        key_next       = key_reg;
        wr_en          = 1'b0;
        wr_addr        = front_reg;
        wr_data        = in_val;
        rd_en          = 1'b0;
        rd_addr        = front_reg;
        res_load       = 1'b0;
        res            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.func)
                        FN_PUSH_FRONT:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                front_next = step_down(front_reg, cap_eff);
                                wr_en      = 1'b1;
                                wr_addr    = front_next;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = back_reg;
                                back_next  = step_up(back_reg, cap_eff);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (!has_entries)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                front_next = step_up(front_reg, cap_eff);
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_READ;
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (!has_entries)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                back_next  = step_down(back_reg, cap_eff);
                                rd_en      = 1'b1;
                                rd_addr    = back_next;
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_READ;
                            end
                        end
                        FN_CLEAR:
                        begin
                            res_load   = 1'b1;
                            front_next = '0;
                            back_next  = '0;
                            count_next = '0;
                        end
                        FN_SEARCH:
                        begin
                            key_next       = in_val;
                            srch_ptr_next  = front_reg;
                            srch_left_next = count_reg;
                            cmp_vld_next   = 1'b0;
                            state_next     = S_SEARCH;
                        end
                        FN_PEEK:
                        begin
                            if (!has_entries)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                    res.occupancy = count_next;
                end
            end
            S_READ:
            begin
                // Hand out the read word once the output is free
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res.data_out   = rd_data_ext;
                    res.occupancy  = count_reg;
                    state_next     = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                // Compare the last read slot, read the next one meanwhile
                if (hit || (!cmp_vld_reg && (srch_left_reg == '0)))
                begin
                    if (out_free)
                    begin
                        res_load       = 1'b1;
                        res.status     = hit ? ST_OK : ST_NOTFOUND;
                        res.slot_index = hit ? cmp_slot : '0;
                        res.occupancy  = count_reg;
                        cmp_vld_next   = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmp_vld_next = (srch_left_reg != '0);
                    if (srch_left_reg != '0)
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = srch_ptr_reg;
                        cmp_ptr_next   = srch_ptr_reg;
                        srch_ptr_next  = step_up(srch_ptr_reg, cap_eff);
                        srch_left_next = srch_left_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load the output register, drop the word once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CFG_W'(16);
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cmp_vld_reg   <= cmp_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        srch_ptr_reg  <= srch_ptr_next;
        srch_left_reg <= srch_left_next;
        cmp_ptr_reg   <= cmp_ptr_next;
        key_reg       <= key_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

>>> bench/circular_double_ended_queue_top_tb.sv
// ----------------------------------------------------------------------------
// Circular deque testbench
// Drives command words into the deque and checks every result word against
// a behavioural predictor kept in step with each accepted command. A short
// directed pass is followed by randomised traffic across capacity settings,
// with random idling on both channels and a final stretch at full rate.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 8;
    localparam int SHOW_LIMIT  = 10;

    // Unused command code: no operation
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_word_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_word_t          out_data;

    // Predictor state
    logic [DATA_IO_W-1:0] slot_mem [DEPTH];
    bit                   slot_written [DEPTH];
    logic [SLOT_W-1:0]    front_ptr  = '0;
    logic [SLOT_W-1:0]    back_ptr   = '0;
    logic [OCC_W-1:0]     fill_count = '0;
    logic [CFG_W-1:0]     cap_reg    = 5'd16;

    out_word_t expected_results [$];

    bit src_idle_en  = 1'b0;
    bit sink_idle_en = 1'b0;
    int stall_left   = 0;

    int cycle_count    = 0;
    int cmd_count      = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int setting_count  = 0;
    int status_seen [4];

    circular_double_ended_queue_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAIL circular_double_ended_queue_top");
            $finish;
        end
    end

    // Pointer stepping at the effective capacity
    function automatic int ptr_up(input int p, input int cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic int ptr_down(input int p, input int cap);
        return (p == 0) ? cap - 1 : p - 1;
    endfunction

    // Work out the result of one command; commit the new state only when
    // asked. Return high if the command would read a slot never written.
    function automatic bit deque_step(input in_word_t w, input bit commit,
                                      output out_word_t r);
        int   cap;
        int   head;
        int   tail;
        int   cnt;
        int   p;
        bit   unsafe;
        logic [DATA_IO_W-1:0] val;
        cap    = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
        head   = int'(front_ptr);
        tail   = int'(back_ptr);
        cnt    = int'(fill_count);
        val    = w.data_in;
        unsafe = 1'b0;
        r      = '0;
        case (w.func)
            FN_PUSH_FRONT:
                if (cnt >= cap)
                    r.status = ST_FULL;
                else
                begin
                    head = ptr_down(head, cap);
                    if (commit)
                    begin
                        slot_mem[head]     = val;
                        slot_written[head] = 1'b1;
                    end
                    cnt++;
                end
            FN_PUSH_BACK:
                if (cnt >= cap)
                    r.status = ST_FULL;
                else
                begin
                    if (commit)
                    begin
                        slot_mem[tail]     = val;
                        slot_written[tail] = 1'b1;
                    end
                    tail = ptr_up(tail, cap);
                    cnt++;
                end
            FN_POP_FRONT:
                if (cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    unsafe     = !slot_written[head];
                    r.data_out = slot_mem[head];
                    head       = ptr_up(head, cap);
                    cnt--;
                end
            FN_POP_BACK:
                if (cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    tail       = ptr_down(tail, cap);
                    unsafe     = !slot_written[tail];
                    r.data_out = slot_mem[tail];
                    cnt--;
                end
            FN_CLEAR:
            begin
                cnt  = 0;
                head = 0;
                tail = 0;
            end
            FN_SEARCH:
            begin
                r.status = ST_NOTFOUND;
                p = head;
                for (int i = 0; i < cnt && i < DEPTH; i++)
                begin
                    if (!slot_written[p])
                        unsafe = 1'b1;
                    if (slot_mem[p] == val)
                    begin
                        r.status     = ST_OK;
                        r.slot_index = SLOT_W'(p);
                        break;
                    end
                    p = ptr_up(p, cap);
                end
            end
            FN_PEEK:
                if (cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    unsafe     = !slot_written[head];
                    r.data_out = slot_mem[head];
                end
            default: ;
        endcase
        r.occupancy = OCC_W'(cnt);
        if (commit)
        begin
            front_ptr  = SLOT_W'(head);
            back_ptr   = SLOT_W'(tail);
            fill_count = OCC_W'(cnt);
        end
        return unsafe;
    endfunction

    // Push a command word through the handshake and record its result
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [DATA_IO_W-1:0] d);
        in_word_t  w;
        out_word_t r;
        w.func    = f;
        w.data_in = d;
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (in_stall);
        void'(deque_step(w, 1'b1, r));
        expected_results.push_back(r);
        cmd_count++;
        @(negedge clk);
    endtask

    // Hold the command channel low until every result has come back
    task automatic wait_idle();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_reg = v;
        setting_count++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Value mix: extremes, a small pool that repeats, and wide random words
    function automatic logic [DATA_IO_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            1, 2, 3, 4: return 32'(int'($urandom_range(0, 7)) - 4);
            default:    return $urandom;
        endcase
    endfunction

    // Value held k entries behind the front, or a fresh value if unknown
    function automatic logic [DATA_IO_W-1:0] live_value(input int k);
        int cap;
        int p;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
        p   = int'(front_ptr);
        for (int i = 0; i < k; i++)
            p = ptr_up(p, cap);
        return slot_written[p] ? slot_mem[p] : pick_value();
    endfunction

    // Random commands; push_pct sets the balance of pushes against pops
    task automatic random_burst(input int n, input int push_pct);
        logic [FUNC_W-1:0]    f;
        logic [DATA_IO_W-1:0] d;
        in_word_t             w;
        out_word_t            r;
        int                   roll;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            d    = pick_value();
            if (roll == 0)
                f = FN_UNUSED;
            else if (roll < 3)
                f = FN_CLEAR;
            else if (roll < 9)
                f = FN_PEEK;
            else if (roll < 19)
            begin
                f = FN_SEARCH;
                if (fill_count != 0 && $urandom_range(0, 3) != 0)
                    d = live_value($urandom_range(0, fill_count - 1));
            end
            else if ($urandom_range(0, 99) < push_pct)
                f = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
            else
                f = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
            // Steer clear of reads from slots never written
            w.func    = f;
            w.data_in = d;
            if (deque_step(w, 1'b0, r))
            begin
                f = FN_PUSH_BACK;
                d = pick_value();
            end
            send_cmd(f, d);
        end
    endtask

    // Every command, empty and full cases, wrap of the front pointer
    task automatic test_directed();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_cmd(FN_POP_FRONT, 32'h0);
        send_cmd(FN_POP_BACK, 32'h0);
        send_cmd(FN_PEEK, 32'h0);
        send_cmd(FN_SEARCH, 32'h0);
        send_cmd(FN_PUSH_FRONT, 32'h7FFF_FFFF);
        send_cmd(FN_PUSH_BACK, 32'h8000_0000);
        send_cmd(FN_PUSH_FRONT, 32'h0000_0000);
        send_cmd(FN_PUSH_BACK, 32'hFFFF_FFFF);
        send_cmd(FN_PEEK, 32'h5A5A_5A5A);
        send_cmd(FN_SEARCH, 32'h8000_0000);
        send_cmd(FN_SEARCH, 32'h0001_2345);
        send_cmd(FN_UNUSED, 32'hFFFF_FFFF);
        send_cmd(FN_POP_BACK, 32'h0);
        send_cmd(FN_POP_FRONT, 32'h0);
        send_cmd(FN_CLEAR, 32'h0);
        send_cmd(FN_POP_FRONT, 32'h0);
        // Single slot: full at once
        write_capacity(5'd1);
        send_cmd(FN_PUSH_BACK, 32'h1234_5678);
        send_cmd(FN_PUSH_FRONT, 32'h1111_1111);
        send_cmd(FN_PUSH_BACK, 32'h2222_2222);
        send_cmd(FN_PEEK, 32'h0);
        send_cmd(FN_POP_BACK, 32'h0);
        send_cmd(FN_PUSH_FRONT, 32'hDEAD_BEEF);
        send_cmd(FN_POP_FRONT, 32'h0);
    endtask

    // Step through capacity settings with entries left in place
    task automatic test_capacity_sweep();
        logic [CFG_W-1:0] caps [10];
        caps = '{5'd0, 5'd16, 5'd2, 5'd31, 5'd15, 5'd17, 5'd3, 5'd16, 5'd0, 5'd8};
        for (int s = 0; s < 10; s++)
        begin
            if (s == 9)
                caps[s] = CFG_W'($urandom_range(0, 31));
            write_capacity(caps[s]);
            random_burst(25, (s % 2 == 0) ? 75 : 30);
        end
    endtask

    // Long random traffic, filling and draining in turn
    task automatic test_random_traffic();
        for (int ph = 0; ph < 9; ph++)
        begin
            if ($urandom_range(0, 2) == 0)
                write_capacity(CFG_W'($urandom_range(0, 31)));
            else
                write_capacity(CFG_W'($urandom_range(1, 6)));
            random_burst(50, (ph % 3 == 0) ? 85 : ((ph % 3 == 1) ? 25 : 55));
        end
    endtask

    // Back-to-back commands with no idling on either side
    task automatic test_steady_stream();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_capacity(5'd16);
        random_burst(75, 85);
        random_burst(75, 20);
    endtask

    // Result-side stall bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall = 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_stall  = 1'b1;
            end
            else
                out_stall = 1'b0;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            status_seen[out_data.status]++;
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < SHOW_LIMIT)
                    $display("unexpected result word %0d: status %0d data %h slot %0d occ %0d",
                             result_count, out_data.status, out_data.data_out,
                             out_data.slot_index, out_data.occupancy);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status || out_data.data_out !== want.data_out ||
                    out_data.slot_index !== want.slot_index ||
                    out_data.occupancy !== want.occupancy)
                begin
                    if (mismatch_count < SHOW_LIMIT)
                    begin
                        $display("result %0d mismatch: expected status %0d data %h slot %0d occ %0d",
                                 result_count, want.status, want.data_out,
                                 want.slot_index, want.occupancy);
                        $display("    actual   status %0d data %h slot %0d occ %0d",
                                 out_data.status, out_data.data_out,
                                 out_data.slot_index, out_data.occupancy);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int leftover;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_mem[i]     = '0;
            slot_written[i] = 1'b0;
        end
        // Hold reset low, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_capacity_sweep();
        test_random_traffic();
        test_steady_stream();

        // Drain, then watch for stray result words
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        leftover = expected_results.size();

        $display("Covered %0d commands, %0d results, %0d capacity writes in %0d cycles",
                 cmd_count, result_count, setting_count, cycle_count);
        $display("Statuses seen: ok %0d, full %0d, empty %0d, not found %0d; mismatches %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND], mismatch_count);
        if (mismatch_count == 0 && leftover == 0)
            $display("PASS circular_double_ended_queue_top");
        else
            $display("FAIL circular_double_ended_queue_top");
        $finish;
    end

endmodule
